// ===== rtl/buis_pkg.sv =====
// Package for the bounded unique id set: sizes, op codes, transaction
// structs and the store request struct. No dependencies.
package buis_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 6;
  localparam int CNTO_W   = 7;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [KEY_W-1:0] key;
  } buis_in_t;

  typedef struct packed {
    logic              status;
    logic              found;
    logic [POS_W-1:0]  position;
    logic [CNTO_W-1:0] count;
    logic              is_empty;
    logic              is_full;
  } buis_out_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [KEY_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } buis_mem_req_t;

endpackage

// ===== rtl/buis_store.sv =====
// Entry store: one write port, one read port with registered read data.
// Depends on buis_pkg.
module buis_store import buis_pkg::*; (
  input  logic             clk,
  input  buis_mem_req_t    req,
  output logic [KEY_W-1:0] rdata
);

  logic [KEY_W-1:0] mem [CAPACITY];
  logic [KEY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bounded_unique_id_set_unit.sv =====
// Bounded unique id set: sequential search over the packed store, append on
// add, swap-remove on delete. Depends on buis_pkg and buis_store.
// Search reads held slots from 0 and resolves on a hit or at the last held slot, or
// at once for a negative id or empty set; a swap-remove adds the swap state. The
// registered strobe follows; the receiver cannot stall it. One store read per cycle;
// start is ignored when busy. Synchronous reset empties the set; stale slots unread.
module bounded_unique_id_set_unit import buis_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  buis_in_t  in_data,
  output logic      out_valid,
  output buis_out_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_SWAP   = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  chk_r, chk_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic              out_valid_r, out_valid_nxt;
  buis_out_t         out_r, out_nxt;

  buis_mem_req_t     mreq;
  logic [KEY_W-1:0]  rdata;

  logic              resolve;
  logic              r_fnd;
  logic [IDX_W-1:0]  r_pos;
  logic              done;
  logic              d_status;
  logic              d_fnd;
  logic [IDX_W-1:0]  d_pos;
  logic              accept;
  logic              neg;
  logic              hit;
  logic              last_chk;
  logic [CNT_W-1:0]  last_idx;

  buis_store u_store (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  assign accept   = start && !busy;
  assign neg      = key_r[KEY_W-1];
  assign hit      = (rdata == key_r);
  assign last_chk = ((CNT_W'(chk_r) + 1'b1) == cnt_r);
  assign last_idx = cnt_r - 1'b1;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    cnt_nxt       = cnt_r;
    chk_nxt       = chk_r;
    pos_nxt       = pos_r;
    mreq          = '0;
    resolve       = 1'b0;
    r_fnd         = 1'b0;
    r_pos         = '0;
    done          = 1'b0;
    d_status      = 1'b0;
    d_fnd         = 1'b0;
    d_pos         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt     = in_data.op;
          key_nxt    = in_data.key;
          chk_nxt    = '0;
          mreq.re    = 1'b1;
          mreq.raddr = '0;
          state_nxt  = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (neg || cnt_r == '0) begin
          resolve = 1'b1;
        end else if (hit || last_chk) begin
          resolve = 1'b1;
          r_fnd   = hit;
          r_pos   = hit ? chk_r : '0;
        end else begin
          chk_nxt    = chk_r + 1'b1;
          mreq.re    = 1'b1;
          mreq.raddr = chk_r + 1'b1;
        end
      end
      S_SWAP: begin
        mreq.we    = 1'b1;
        mreq.waddr = pos_r;
        mreq.wdata = rdata;
        cnt_nxt    = last_idx;
        done       = 1'b1;
        d_fnd      = 1'b1;
        d_pos      = pos_r;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (resolve) begin
      d_fnd   = r_fnd;
      d_pos   = r_pos;
      pos_nxt = r_pos;
      done    = 1'b1;
      case (op_r)
        OP_ADD: begin
          if (neg || r_fnd || cnt_r >= CNT_W'(CAPACITY)) begin
            d_status = 1'b1;
          end else begin
            mreq.we    = 1'b1;
            mreq.waddr = cnt_r[IDX_W-1:0];
            mreq.wdata = key_r;
            cnt_nxt    = cnt_r + 1'b1;
          end
        end
        OP_DELETE: begin
          if (!r_fnd) begin
            d_status = 1'b1;
          end else if (CNT_W'(r_pos) == last_idx) begin
            cnt_nxt = last_idx;
          end else begin
            mreq.re    = 1'b1;
            mreq.raddr = last_idx[IDX_W-1:0];
            done       = 1'b0;
            state_nxt  = S_SWAP;
          end
        end
        default: begin
        end
      endcase
    end

    if (done) begin
      state_nxt = S_IDLE;
    end

    out_valid_nxt     = done;
    out_nxt           = out_r;
    if (done) begin
      out_nxt.status   = d_status;
      out_nxt.found    = d_fnd;
      out_nxt.position = POS_W'(d_pos);
      out_nxt.count    = CNTO_W'(cnt_nxt);
      out_nxt.is_empty = (cnt_nxt == '0);
      out_nxt.is_full  = (cnt_nxt == CNT_W'(CAPACITY));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r  <= op_nxt;
    key_r <= key_nxt;
    chk_r <= chk_nxt;
    pos_r <= pos_nxt;
    out_r <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("held count above capacity");

  a_chk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH && cnt_r != '0) |-> (CNT_W'(chk_r) < cnt_r))
    else $error("search index beyond held count");

  a_start_prog: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted transaction did not enter search");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while still busy");

  a_swap_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWAP) |=> (out_valid_r && out_r.found && !out_r.status))
    else $error("swap-remove did not complete as a good delete");

endmodule

// ===== tb/sv/buis_tb_pkg.sv =====
// Scoreboard for the bounded unique id set testbench: an own model of the
// packed store and a queue of expected results. Depends on buis_pkg.
package buis_tb_pkg;
  import buis_pkg::*;

  localparam logic [1:0]       OP_LOOKUP = 2'd2;
  localparam logic [1:0]       OP_SPARE  = 2'd3;
  localparam logic [KEY_W-1:0] FREE_SLOT = '1;

  class id_set_scoreboard;
    logic [KEY_W-1:0] slots [CAPACITY];
    int unsigned      held;
    buis_out_t        pending [$];
    int unsigned      errors;
    int unsigned      results;
    int unsigned      by_op [4];
    int unsigned      full_seen;
    int unsigned      empty_seen;

    function new();
      foreach (slots[i]) slots[i] = FREE_SLOT;
      held       = 0;
      errors     = 0;
      results    = 0;
      full_seen  = 0;
      empty_seen = 0;
      foreach (by_op[i]) by_op[i] = 0;
    endfunction

    // Accepted transaction: update the set and queue the expected result.
    function void note_cmd(buis_in_t cmd);
      buis_out_t   want;
      bit          hit;
      int unsigned pos;
      int unsigned last;
      hit = 1'b0;
      pos = 0;
      if (!cmd.key[KEY_W-1]) begin
        for (int unsigned i = 0; i < held; i++) begin
          if (!hit && slots[i] == cmd.key) begin
            hit = 1'b1;
            pos = i;
          end
        end
      end
      want.status = 1'b0;
      case (cmd.op)
        OP_ADD: begin
          if (cmd.key[KEY_W-1] || held >= CAPACITY || hit) begin
            want.status = 1'b1;
          end else begin
            slots[held] = cmd.key;
            held++;
          end
        end
        OP_DELETE: begin
          if (held == 0 || !hit) begin
            want.status = 1'b1;
          end else begin
            last        = held - 1;
            slots[pos]  = slots[last];
            slots[last] = FREE_SLOT;
            held        = last;
          end
        end
        default: ;
      endcase
      want.found    = hit;
      want.position = hit ? POS_W'(pos) : '0;
      want.count    = CNTO_W'(held);
      want.is_empty = (held == 0);
      want.is_full  = (held == CAPACITY);
      if (want.is_full) full_seen++;
      if (want.is_empty) empty_seen++;
      by_op[cmd.op]++;
      pending.push_back(want);
    endfunction

    function void check_field(string name, logic [CNTO_W-1:0] want, logic [CNTO_W-1:0] got);
      if (got !== want) begin
        $error("%s expected %0d got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(buis_out_t got);
      buis_out_t want;
      results++;
      if (pending.size() == 0) begin
        $error("result strobe with no transaction outstanding");
        errors++;
        return;
      end
      want = pending.pop_front();
      check_field("status", CNTO_W'(want.status), CNTO_W'(got.status));
      check_field("found", CNTO_W'(want.found), CNTO_W'(got.found));
      check_field("position", CNTO_W'(want.position), CNTO_W'(got.position));
      check_field("count", want.count, got.count);
      check_field("is_empty", CNTO_W'(want.is_empty), CNTO_W'(got.is_empty));
      check_field("is_full", CNTO_W'(want.is_full), CNTO_W'(got.is_full));
    endfunction
  endclass

endpackage

// ===== tb/sv/bounded_unique_id_set_unit_tb.sv =====
// Testbench top for bounded_unique_id_set_unit: directed corner transactions,
// then fill/drain/mixed random phases, checked by id_set_scoreboard.
// Depends on buis_pkg, buis_tb_pkg and the RTL.
module bounded_unique_id_set_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import buis_pkg::*;
  import buis_tb_pkg::*;

  localparam int NUM_RANDOM = 1150;
  localparam int POOL_SIZE  = 96;
  localparam int NUM_DIR    = 20;

  localparam logic [1:0] DIR_OPS [NUM_DIR] = '{
    OP_LOOKUP, OP_DELETE, OP_ADD, OP_ADD, OP_ADD, OP_ADD, OP_ADD, OP_LOOKUP,
    OP_LOOKUP, OP_DELETE, OP_DELETE, OP_ADD, OP_ADD, OP_SPARE, OP_DELETE,
    OP_LOOKUP, OP_DELETE, OP_DELETE, OP_DELETE, OP_DELETE
  };
  localparam logic [KEY_W-1:0] DIR_KEYS [NUM_DIR] = '{
    32'd5, 32'd5, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'd0,
    32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd12345, 32'h5555_5555,
    32'h2AAA_AAAA, 32'd0, 32'd0, 32'h2AAA_AAAA, 32'h5555_5555, 32'h2AAA_AAAA,
    32'h7FFF_FFFF, 32'h7FFF_FFFF
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  buis_in_t  cmd_bus = '0;
  logic      out_valid;
  buis_out_t result_bus;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  id_set_scoreboard sb = new();

  bounded_unique_id_set_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (cmd_bus),
    .out_valid(out_valid),
    .out_data (result_bus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (rst_n && out_valid) sb.check_result(result_bus);
  end

  // Leaves start high at the accepting edge; the next call lowers it if it idles.
  task automatic issue_cmd(input logic [1:0] op, input logic [KEY_W-1:0] key,
                           input int unsigned gap);
    buis_in_t cmd;
    cmd.op  = op;
    cmd.key = key;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    cmd_bus <= cmd;
    do @(negedge clk); while (busy !== 1'b0);
    @(posedge clk);
    sb.note_cmd(cmd);
  endtask

  function automatic logic [KEY_W-1:0] pick_key(input int unsigned held_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < held_pct && sb.held > 0) return sb.slots[$urandom_range(0, sb.held - 1)];
    if (roll < 90) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom();
  endfunction

  initial begin : stimulus
    int unsigned sent;
    int unsigned phase;
    int unsigned plen;
    int unsigned add_pct;
    int unsigned del_pct;
    int unsigned roll;
    bit          quiet;
    logic [1:0]  op;
    key_pool[0] = '0;
    key_pool[1] = 32'h7FFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom() & 32'h7FFF_FFFF;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_DIR; i++) issue_cmd(DIR_OPS[i], DIR_KEYS[i], $urandom_range(0, 15));

    sent  = 0;
    phase = 0;
    while (sent < NUM_RANDOM) begin
      case (phase % 3)
        0: begin add_pct = 75; del_pct = 10; plen = 150; end
        1: begin add_pct = 40; del_pct = 35; plen = $urandom_range(40, 120); end
        default: begin add_pct = 10; del_pct = 75; plen = 150; end
      endcase
      quiet = ($urandom_range(0, 2) == 0);
      for (int unsigned n = 0; n < plen && sent < NUM_RANDOM; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < add_pct) op = OP_ADD;
        else if (roll < add_pct + del_pct) op = OP_DELETE;
        else op = ($urandom_range(0, 3) == 0) ? OP_SPARE : OP_LOOKUP;
        issue_cmd(op, pick_key(op == OP_ADD ? 15 : 65), quiet ? 0 : $urandom_range(0, 15));
        sent++;
      end
      phase++;
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (CAPACITY + 4) @(posedge clk);
    $display("covered %0d transactions: %0d add, %0d delete, %0d lookup, %0d spare op",
             sb.by_op[OP_ADD] + sb.by_op[OP_DELETE] + sb.by_op[OP_LOOKUP] + sb.by_op[OP_SPARE],
             sb.by_op[OP_ADD], sb.by_op[OP_DELETE], sb.by_op[OP_LOOKUP], sb.by_op[OP_SPARE]);
    $display("%0d results checked; set full after %0d, empty after %0d transactions",
             sb.results, sb.full_seen, sb.empty_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("bounded_unique_id_set_unit_tb OK");
    end else begin
      $display("bounded_unique_id_set_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #6_000_000;
    $display("bounded_unique_id_set_unit_tb NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/buis_pkg.sv
rtl/buis_store.sv
rtl/bounded_unique_id_set_unit.sv
tb/sv/buis_tb_pkg.sv
tb/sv/bounded_unique_id_set_unit_tb.sv
